// ----- sv/hsht_pkg.sv -----
// Shared types, constants and the slot hash for the hidden-streak hysteresis table.
`default_nettype none
package hsht_pkg;

  localparam int INDEX_BITS  = 14;
  localparam int KEY_BITS    = 48;
  localparam int FRAME_BITS  = 32;
  localparam int STREAK_BITS = 8;
  localparam int HIDE_BITS   = 8;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int PADDR_BITS  = 2;
  localparam int PDATA_BITS  = 32;

  localparam logic [31:0]            HASH_MUL   = 32'd2654435761;
  localparam logic [STREAK_BITS-1:0] STREAK_MAX = {STREAK_BITS{1'b1}};
  localparam logic [HIDE_BITS-1:0]   HIDE_RESET = 8'd2;

  // register index of hide_frames (word address)
  localparam logic [PADDR_BITS-1:0] REG_HIDE_FRAMES = '0;

  typedef struct packed {
    logic [KEY_BITS-1:0]   object_key;
    logic                  hidden;
    logic [FRAME_BITS-1:0] frame_number;
  } item_t;

  typedef struct packed {
    logic cull;
    logic flip;
    logic deferred;
    logic slot_replaced;
  } result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [FRAME_BITS-1:0]  frame;
    logic [STREAK_BITS-1:0] streak;
    logic                   last_hidden;
  } slot_entry_t;

  localparam int ENTRY_BITS = $bits(slot_entry_t);

  // slot = bits 31..32-INDEX_BITS of ((key >> 4) * HASH_MUL) mod 2^32
  function automatic logic [INDEX_BITS-1:0] slot_of(input logic [KEY_BITS-1:0] key);
    logic [KEY_BITS-1:0] shifted;
    logic [31:0]         prod;
    shifted = key >> 4;
    prod    = shifted[31:0] * HASH_MUL;
    return prod[31 -: INDEX_BITS];
  endfunction

endpackage
`default_nettype wire

// ----- sv/hidden_streak_hysteresis_table.sv -----
// Top level: hidden-streak hysteresis table with a clearing sequencer and APB register.
//
// Usage: raise start with an item (object key, hidden flag, frame number) while busy
// is low; the item is taken at that clock edge. The object key is hashed to one slot
// of a direct-mapped table held in a single synchronous RAM.
// Timing: the edge that takes the item also registers the slot index; the next cycle
// reads the RAM; the cycle after that compares, writes the slot back and registers the
// result. done is registered at the write-back and is high for exactly one cycle,
// with the verdict on result. busy is high from acceptance until the write-back, so
// no new item is taken before the last one is written back; the RAM read latency and
// the read-modify-write of one slot set that limit.
// The receiver cannot stall: done is high for a single cycle per result.
// Reset (rst, synchronous): hide_frames returns to 2 and a clearing pass writes zero
// to all 16384 slots, one slot per cycle, with busy high throughout. APB writes to
// hide_frames are taken at any time, also during the clearing pass.
`default_nettype none
module hidden_streak_hysteresis_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire hsht_pkg::item_t                     item,
  output logic                                     done,
  output hsht_pkg::result_t                        result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [hsht_pkg::PADDR_BITS-1:0]     paddr,
  input  wire logic [hsht_pkg::PDATA_BITS-1:0]     pwdata,
  output logic      [hsht_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                     pready
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_UPDATE} state_t;

  state_t                            state;
  logic [hsht_pkg::INDEX_BITS-1:0]   clr_addr;
  logic [hsht_pkg::INDEX_BITS-1:0]   slot;
  hsht_pkg::item_t                   item_q;
  logic [hsht_pkg::HIDE_BITS-1:0]    hide_frames;

  logic [hsht_pkg::PADDR_BITS-1:0]   reg_idx;
  logic                              accept;
  logic                              ram_we;
  logic [hsht_pkg::INDEX_BITS-1:0]   ram_waddr;
  logic [hsht_pkg::ENTRY_BITS-1:0]   ram_wdata;
  logic [hsht_pkg::ENTRY_BITS-1:0]   ram_rdata;
  hsht_pkg::slot_entry_t             old_entry;
  hsht_pkg::slot_entry_t             new_entry;
  hsht_pkg::result_t                 upd_result;

  assign busy    = state != S_IDLE;
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign reg_idx = paddr >> 2;
  assign prdata  = (reg_idx == hsht_pkg::REG_HIDE_FRAMES)
                   ? {{(hsht_pkg::PDATA_BITS-hsht_pkg::HIDE_BITS){1'b0}}, hide_frames}
                   : '0;

  assign old_entry = hsht_pkg::slot_entry_t'(ram_rdata);

  // clearing pass and write-back share the one write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = new_entry;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_UPDATE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  hsht_ram #(
    .WIDTH (hsht_pkg::ENTRY_BITS),
    .DEPTH (hsht_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  hsht_update u_update (
    .item        (item_q),
    .old_entry   (old_entry),
    .hide_frames (hide_frames),
    .new_entry   (new_entry),
    .result      (upd_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hide_frames <= hsht_pkg::HIDE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == hsht_pkg::REG_HIDE_FRAMES) begin
      hide_frames <= pwdata[hsht_pkg::HIDE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {hsht_pkg::INDEX_BITS{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      slot   <= hsht_pkg::slot_of(item.object_key);
    end
    if (state == S_UPDATE) begin
      result <= upd_result;
    end
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result strobe without a preceding write-back");

  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_READ))
    else $error("accepted item did not start a table read");

  a_verdict_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.cull && result.deferred))
    else $error("cull and deferred both set");

  a_replace_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.slot_replaced) |-> (!result.flip && !result.deferred))
    else $error("replaced slot reported flip or deferred");

endmodule
`default_nettype wire

// ----- sv/hsht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hsht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/hsht_update.sv -----
// Slot update: compares the stored entry with the item and forms the new entry and verdict.
`default_nettype none
module hsht_update (
  input  wire hsht_pkg::item_t                    item,
  input  wire hsht_pkg::slot_entry_t              old_entry,
  input  wire logic [hsht_pkg::HIDE_BITS-1:0]     hide_frames,
  output hsht_pkg::slot_entry_t                   new_entry,
  output hsht_pkg::result_t                       result
);

  logic                              replace;
  logic                              consec;
  logic [hsht_pkg::FRAME_BITS-1:0]   frame_inc;
  logic [hsht_pkg::STREAK_BITS-1:0]  streak;

  always_comb begin
    replace   = old_entry.key != item.object_key;
    frame_inc = old_entry.frame + 1'b1;
    consec    = frame_inc == item.frame_number;

    if (!item.hidden) begin
      streak = '0;
    end else if (consec) begin
      streak = (old_entry.streak == hsht_pkg::STREAK_MAX) ? hsht_pkg::STREAK_MAX
                                                          : old_entry.streak + 1'b1;
    end else begin
      streak = {{(hsht_pkg::STREAK_BITS-1){1'b0}}, 1'b1};
    end

    new_entry.key         = item.object_key;
    new_entry.frame       = item.frame_number;
    new_entry.last_hidden = item.hidden;

    if (replace) begin
      new_entry.streak     = {{(hsht_pkg::STREAK_BITS-1){1'b0}}, item.hidden};
      result.slot_replaced = 1'b1;
      result.flip          = 1'b0;
      result.deferred      = 1'b0;
      result.cull          = item.hidden && (hide_frames <= 8'd1);
    end else begin
      new_entry.streak     = streak;
      result.slot_replaced = 1'b0;
      result.flip          = consec && (old_entry.last_hidden != item.hidden);
      result.deferred      = item.hidden && (streak < hide_frames);
      result.cull          = item.hidden && (streak >= hide_frames);
    end
  end

endmodule
`default_nettype wire
